### rtl/iee_pkg.sv
// Package: shared constants, types and character codes for the expression evaluator.
`timescale 1ns / 1ps
package iee_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 8;
    localparam int MAX_NUMERAL_CHARS_DEF = 19;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] POP_NONE = 2'd0;
    localparam logic [1:0] POP_MUL  = 2'd1;
    localparam logic [1:0] POP_DIV  = 2'd2;

    localparam logic [59:0] MANT_CAP = 60'd1000000000000000000;
    localparam logic [59:0] MANT_LIM = 60'd100000000000000000;

    // datapath commands
    typedef enum logic [3:0] {
        C_NOP, C_CHAR, C_CONV_START, C_CONV_STEP, C_CONV_FIN, C_FRAC_START, C_DIV_STEP,
        C_FRAC_FIN, C_TERM_MUL, C_TERM_DIV_START, C_TERM_DIV_FIN, C_TERM_PASS, C_APPLY_OP,
        C_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ch;
    } t_ctl;

    typedef struct packed {
        logic       is_op;
        logic       after_op;
        logic       div_zero;
    } t_sts;

    function automatic logic [33:0] pow10(input logic [3:0] n);
        case (n)
            4'd0: pow10 = 34'd1;
            4'd1: pow10 = 34'd10;
            4'd2: pow10 = 34'd100;
            4'd3: pow10 = 34'd1000;
            4'd4: pow10 = 34'd10000;
            4'd5: pow10 = 34'd100000;
            4'd6: pow10 = 34'd1000000;
            4'd7: pow10 = 34'd10000000;
            4'd8: pow10 = 34'd100000000;
            default: pow10 = 34'd1000000000;
        endcase
    endfunction
endpackage

### rtl/iee_datapath.sv
// Datapath: numeral accumulation, shared restoring divider, multiplier and sum registers.
`timescale 1ns / 1ps
module iee_datapath #(
    parameter int FRAC_BITS = iee_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = iee_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int MAX_NUMERAL_CHARS = iee_pkg::MAX_NUMERAL_CHARS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iee_pkg::t_ctl       i_ctl,
    output iee_pkg::t_sts       o_sts,
    output logic [1:0]          o_pop,
    output logic [31:0]         o_value,
    output logic [1:0]          o_status
);
    import iee_pkg::*;

    localparam int LW = $clog2(MAX_NUMERAL_CHARS + 1);
    localparam int DW = 64;               // divider width

    logic signed [31:0] r_sum, r_term, r_num;
    logic               r_sub;
    logic [1:0]         r_pop, r_err;
    logic [59:0]        r_mant;
    logic [3:0]         r_fcnt;
    logic               r_infrac, r_closed, r_after;
    logic [LW-1:0]      r_len;
    // divider
    logic [DW-1:0]      r_dq, r_dd;
    logic [DW:0]        r_rem;
    logic               r_neg;
    logic [59:0]        r_q;
    logic [33:0]        r_scale;
    logic signed [63:0] r_prod;
    logic [7:0]         r_opch;

    logic [7:0] ch;
    logic       is_op, is_dig;
    logic [DW:0] trial;
    logic [3:0]  dig;
    logic [1:0]  n_err;
    logic        conv_ovf, mul_hi, mul_lo, div_ovf, sum_hi, sum_lo;

    assign ch = i_ctl.ch;
    assign is_op = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
    assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dig = 4'(ch - CH_ZERO);
    assign trial = {r_rem[DW-1:0], r_dq[DW-1]} - {1'b0, r_dd};

    assign o_sts.is_op = is_op;
    assign o_sts.after_op = r_after;
    assign o_sts.div_zero = (r_num == 32'sd0);
    assign o_pop = r_pop;
    assign o_value = r_sum;
    assign o_status = r_err;

    // add/sub of term into running sum
    logic signed [33:0] s_ext;
    always_comb begin
        s_ext = r_sub ? (34'(r_sum) - 34'(r_term)) : (34'(r_sum) + 34'(r_term));
    end

    assign conv_ovf = (r_q > 60'(32'h7FFFFFFF >> FRAC_BITS)) ||
                      ((r_q << FRAC_BITS) + 60'(r_dq) > 60'h7FFFFFFF);
    assign mul_hi = (r_prod >>> FRAC_BITS) > 64'sh7FFFFFFF;
    assign mul_lo = (r_prod >>> FRAC_BITS) < -64'sh80000000;
    assign div_ovf = r_neg ? (r_dq > 64'h80000000) : (r_dq > 64'h7FFFFFFF);
    assign sum_hi = s_ext > 34'sh7FFFFFFF;
    assign sum_lo = s_ext < -34'sh80000000;

    // keep the first error of the expression
    always_comb begin
        n_err = r_err;
        unique case (i_ctl.cmd)
            C_CONV_FIN:       if (conv_ovf) n_err = ST_OVF;
            C_FRAC_FIN:       if (mul_hi || mul_lo) n_err = ST_OVF;
            C_TERM_DIV_START: if (r_num == 32'sd0) n_err = ST_DIV0;
            C_TERM_DIV_FIN:   if (div_ovf) n_err = ST_OVF;
            C_TERM_PASS:      if (sum_hi || sum_lo) n_err = ST_OVF;
            default: ;
        endcase
        if (r_err != ST_OK) n_err = r_err;
        if (i_ctl.cmd == C_CLEAR) n_err = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0; r_sub <= 1'b0; r_term <= '0; r_pop <= POP_NONE; r_err <= ST_OK;
            r_mant <= '0; r_fcnt <= '0; r_infrac <= 1'b0; r_closed <= 1'b0;
            r_len <= '0; r_after <= 1'b1; r_num <= '0;
        end else begin
            r_err <= n_err;
            unique case (i_ctl.cmd)
                C_CHAR: begin
                    r_opch <= ch;
                    if (!is_op) begin
                        r_after <= 1'b0;
                        if (r_len < LW'(MAX_NUMERAL_CHARS)) begin
                            r_len <= r_len + LW'(1);
                            if (!r_closed) begin
                                if (is_dig) begin
                                    if (!r_infrac || r_fcnt < 4'(MAX_FRAC_DIGITS)) begin
                                        r_mant <= (r_mant >= MANT_LIM) ? MANT_CAP
                                            : 60'(r_mant * 60'd10) + 60'(dig);
                                        if (r_infrac) r_fcnt <= r_fcnt + 4'd1;
                                    end
                                end else if (ch == CH_POINT) begin
                                    if (r_infrac) r_closed <= 1'b1;
                                    else r_infrac <= 1'b1;
                                end else begin
                                    r_closed <= 1'b1;
                                end
                            end
                        end
                    end
                end
                C_CONV_START: begin
                    // mantissa / 10^cnt
                    r_scale <= pow10(r_fcnt);
                    r_dq <= 64'(r_mant); r_dd <= 64'(pow10(r_fcnt));
                    r_rem <= '0;
                end
                C_DIV_STEP: begin
                    if (!trial[DW]) begin
                        r_rem <= trial; r_dq <= {r_dq[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DW-1:0], r_dq[DW-1]}; r_dq <= {r_dq[DW-2:0], 1'b0};
                    end
                end
                C_CONV_STEP: begin
                    r_q <= 60'(r_dq);
                    // fraction: ((rem<<F) + scale/2) / scale
                    r_dq <= 64'((r_rem[33:0] << FRAC_BITS) + 64'(r_scale >> 1));
                    r_dd <= 64'(r_scale); r_rem <= '0;
                end
                C_CONV_FIN: begin
                    if (conv_ovf) r_num <= 32'sh7FFFFFFF;
                    else r_num <= 32'((r_q << FRAC_BITS) + 60'(r_dq));
                    r_mant <= '0; r_fcnt <= '0; r_infrac <= 1'b0; r_closed <= 1'b0;
                    r_len <= '0;
                end
                C_TERM_MUL: begin
                    r_prod <= 64'(r_term) * 64'(r_num);
                end
                C_FRAC_FIN: begin
                    // floor shift, saturate
                    if (mul_hi) r_num <= 32'sh7FFFFFFF;
                    else if (mul_lo) r_num <= 32'sh80000000;
                    else r_num <= 32'(r_prod >>> FRAC_BITS);
                end
                C_TERM_DIV_START: begin
                    if (r_num == 32'sd0) begin
                        r_num <= r_term[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
                    end else begin
                        r_neg <= r_term[31] ^ r_num[31];
                        r_dq <= 64'(r_term[31] ? -64'(r_term) : 64'(r_term)) << FRAC_BITS;
                        r_dd <= 64'(r_num[31] ? -64'(r_num) : 64'(r_num));
                        r_rem <= '0;
                    end
                end
                C_TERM_DIV_FIN: begin
                    if (div_ovf) r_num <= r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                    else r_num <= r_neg ? 32'(-r_dq) : 32'(r_dq);
                end
                C_APPLY_OP: begin
                    r_after <= 1'b1;
                    r_term <= r_num;
                    if (r_opch == CH_STAR || r_opch == CH_SLASH)
                        r_pop <= (r_opch == CH_STAR) ? POP_MUL : POP_DIV;
                end
                C_TERM_PASS: begin
                    // add r_term into sum with pending sign
                    if (sum_hi) r_sum <= 32'sh7FFFFFFF;
                    else if (sum_lo) r_sum <= 32'sh80000000;
                    else r_sum <= 32'(s_ext);
                    r_sub <= (r_opch == CH_MINUS); r_pop <= POP_NONE;
                end
                C_FRAC_START: begin
                    r_term <= r_num;  // stage term for sum
                end
                C_CLEAR: begin
                    r_sum <= '0; r_sub <= 1'b0; r_term <= '0; r_pop <= POP_NONE;
                    r_after <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/iee_ctrl.sv
// Controller: sequences character handling, numeral conversion, term and sum updates.
`timescale 1ns / 1ps
module iee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_ch,
    input  logic          i_last,
    output logic          o_in_ready,
    input  iee_pkg::t_sts i_sts,
    input  logic [1:0]    i_pop,
    output iee_pkg::t_ctl o_ctl,
    output logic          o_out_valid,
    input  logic          i_out_ready
);
    import iee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CS, S_CD1, S_CM, S_CD2, S_CF, S_TERM, S_MUL, S_MULF, S_DIVS, S_DIVD,
        S_DIVF, S_OPS, S_ADD, S_OUT
    } t_state;

    t_state     r_st;
    logic       r_last, r_op;
    logic [6:0] r_cnt;
    logic [7:0] r_ch;

    assign o_in_ready = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT);

    always_comb begin
        o_ctl.ch = r_ch;
        o_ctl.cmd = C_NOP;
        unique case (r_st)
            S_IDLE: begin
                o_ctl.ch = i_ch;
                if (i_in_valid) o_ctl.cmd = C_CHAR;
            end
            S_CS: o_ctl.cmd = C_CONV_START;
            S_CD1, S_CD2, S_DIVD: o_ctl.cmd = C_DIV_STEP;
            S_CM: o_ctl.cmd = C_CONV_STEP;
            S_CF: o_ctl.cmd = C_CONV_FIN;
            S_MUL: o_ctl.cmd = C_TERM_MUL;
            S_MULF: o_ctl.cmd = C_FRAC_FIN;
            S_DIVS: o_ctl.cmd = C_TERM_DIV_START;
            S_DIVF: o_ctl.cmd = C_TERM_DIV_FIN;
            S_TERM: o_ctl.cmd = C_FRAC_START;
            S_OPS: o_ctl.cmd = C_APPLY_OP;
            S_ADD: o_ctl.cmd = C_TERM_PASS;
            S_OUT: if (i_out_ready) o_ctl.cmd = C_CLEAR;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_last <= 1'b0; r_op <= 1'b0; r_ch <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_in_valid) begin
                    r_ch <= i_ch; r_last <= i_last;
                    r_op <= i_sts.is_op && !i_sts.after_op;
                    if ((i_sts.is_op && !i_sts.after_op) || i_last) r_st <= S_CS;
                end
                S_CS:  begin r_cnt <= 7'd64; r_st <= S_CD1; end
                S_CD1: begin r_cnt <= r_cnt - 1'b1; if (r_cnt == 7'd1) r_st <= S_CM; end
                S_CM:  begin r_cnt <= 7'd64; r_st <= S_CD2; end
                S_CD2: begin r_cnt <= r_cnt - 1'b1; if (r_cnt == 7'd1) r_st <= S_CF; end
                S_CF:  r_st <= (i_pop == POP_MUL) ? S_MUL : (i_pop == POP_DIV) ? S_DIVS
                              : S_OPS;
                S_MUL: r_st <= S_MULF;
                S_MULF: r_st <= S_OPS;
                S_DIVS: begin
                    r_cnt <= 7'd64;
                    r_st <= i_sts.div_zero ? S_OPS : S_DIVD;
                end
                S_DIVD: begin r_cnt <= r_cnt - 1'b1; if (r_cnt == 7'd1) r_st <= S_DIVF; end
                S_DIVF: r_st <= S_OPS;
                S_OPS: begin
                    // mul/div op: term stored; otherwise fold into sum
                    if (r_op && (r_ch == CH_STAR || r_ch == CH_SLASH)) begin
                        // trailing mul/div: run again with the empty numeral as operand
                        if (r_last) begin
                            r_op <= 1'b0;
                            r_st <= S_CS;
                        end else r_st <= S_IDLE;
                    end else r_st <= S_TERM;
                end
                S_TERM: r_st <= S_ADD;
                S_ADD: r_st <= r_last ? S_OUT : S_IDLE;
                S_OUT: if (i_out_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/infix_expression_evaluator.sv
// Top level: expression evaluator with streaming character input and result output.
// Sequence: a plain character is taken while idle; an accepted operator or the final character
// runs numeral conversion (two 64-step divides) plus the term and sum update; a trailing
// multiply or divide repeats the pass with a zero operand.
// Throughput: one item at a time; s_axis_tready stays low until the item is fully handled.
// Reset: synchronous active-low i_rst_n clears the sum, pending op and status.
`timescale 1ns / 1ps
module infix_expression_evaluator #(
    parameter int FRAC_BITS = iee_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = iee_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int MAX_NUMERAL_CHARS = iee_pkg::MAX_NUMERAL_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // value[31:0], status[33:32], zero fill
);
    import iee_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic [31:0] value;
    logic [1:0]  status;
    logic [1:0]  pop;

    iee_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
                   .MAX_NUMERAL_CHARS(MAX_NUMERAL_CHARS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts), .o_pop(pop),
        .o_value(value), .o_status(status)
    );

    iee_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_ch(s_axis_tdata), .i_last(s_axis_tlast), .o_in_ready(s_axis_tready),
        .i_sts(sts), .i_pop(pop), .o_ctl(ctl),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, status, value};

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("in and out overlap");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
